>>> rtl/sc2a_pkg.sv
`default_nettype none

package sc2a_pkg;

	// Special scancodes (full byte, make only)
	localparam logic [7:0] CODE_BACKSPACE = 8'h0E;
	localparam logic [7:0] CODE_ENTER     = 8'h1C;

	// Highest key index covered by the layout table
	localparam logic [6:0] KEY_LAST_PRINTABLE = 7'd57;

	// Modifier key indexes
	localparam logic [6:0] KEY_LCTRL  = 7'd29;
	localparam logic [6:0] KEY_LSHIFT = 7'd42;
	localparam logic [6:0] KEY_RSHIFT = 7'd54;
	localparam logic [6:0] KEY_LALT   = 7'd56;

	// Modifier bit positions
	localparam int unsigned MOD_SHIFT = 0;
	localparam int unsigned MOD_CTRL  = 1;
	localparam int unsigned MOD_ALT   = 3;

	// Event kinds
	localparam logic [1:0] EV_ECHO    = 2'd0;
	localparam logic [1:0] EV_ERASE   = 2'd1;
	localparam logic [1:0] EV_NEWLINE = 2'd2;

	localparam logic [6:0] ASCII_UPPER_A = 7'h41;
	localparam logic [6:0] ASCII_UPPER_Z = 7'h5A;
	localparam logic [6:0] ASCII_CASE_OFS = 7'h20;

	typedef struct packed {
		logic [7:0] scan_code;
	} scan_item_t;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [6:0] char_code;
		logic [3:0] modifier_bits;
		logic       last_of_run;
	} event_item_t;

	// US layout, set 1; zero marks a non-printable key
	function automatic logic [6:0] key_char(input logic [6:0] key);
		logic [6:0] c;
		case (key)
			7'd2:  c = 7'h31; // 1
			7'd3:  c = 7'h32;
			7'd4:  c = 7'h33;
			7'd5:  c = 7'h34;
			7'd6:  c = 7'h35;
			7'd7:  c = 7'h36;
			7'd8:  c = 7'h37;
			7'd9:  c = 7'h38;
			7'd10: c = 7'h39;
			7'd11: c = 7'h30; // 0
			7'd12: c = 7'h2D; // -
			7'd13: c = 7'h3D; // =
			7'd16: c = 7'h51; // Q
			7'd17: c = 7'h57;
			7'd18: c = 7'h45;
			7'd19: c = 7'h52;
			7'd20: c = 7'h54;
			7'd21: c = 7'h59;
			7'd22: c = 7'h55;
			7'd23: c = 7'h49;
			7'd24: c = 7'h4F;
			7'd25: c = 7'h50; // P
			7'd26: c = 7'h5B; // [
			7'd27: c = 7'h5D; // ]
			7'd30: c = 7'h41; // A
			7'd31: c = 7'h53;
			7'd32: c = 7'h44;
			7'd33: c = 7'h46;
			7'd34: c = 7'h47;
			7'd35: c = 7'h48;
			7'd36: c = 7'h4A;
			7'd37: c = 7'h4B;
			7'd38: c = 7'h4C; // L
			7'd39: c = 7'h3B; // ;
			7'd40: c = 7'h27; // quote
			7'd41: c = 7'h60; // backtick
			7'd43: c = 7'h5C; // backslash
			7'd44: c = 7'h5A; // Z
			7'd45: c = 7'h58;
			7'd46: c = 7'h43;
			7'd47: c = 7'h56;
			7'd48: c = 7'h42;
			7'd49: c = 7'h4E;
			7'd50: c = 7'h4D; // M
			7'd51: c = 7'h2C; // ,
			7'd52: c = 7'h2E; // .
			7'd53: c = 7'h2F; // /
			7'd57: c = 7'h20; // space
			default: c = 7'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

>>> rtl/sc2a_scan_if.sv
`default_nettype none

interface sc2a_scan_if;
	logic                   valid;
	logic                   ready;
	sc2a_pkg::scan_item_t   payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/sc2a_event_if.sv
`default_nettype none

interface sc2a_event_if;
	logic                   valid;
	logic                   ready;
	sc2a_pkg::event_item_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/scancode_to_ascii_line_editor.sv
`default_nettype none

// Channel   | Dir | Payload                                        | Items
// ----------+-----+------------------------------------------------+-----------------
// scan_in   | in  | scan_code[7:0]                                 | one per scancode
// event_out | out | event_kind[1:0] char_code[6:0] modifier_bits[3:0] last_of_run | 0..2 per scancode
//
// Decode is combinational: a scancode accepted at an edge updates the state and has its
// events queued at that same edge, and on event_out in the next cycle if the queue was empty.
// The queue holds four events; scan_in is ready while at least two slots are free, so a
// new scancode can be taken every cycle as long as event_out drains and no scancode makes two events.
// arst_n clears the modifier bits, the line length and the queue; queue contents need no reset.
// A stall on event_out backs up into scan_in only once the queue is more than half full.

module scancode_to_ascii_line_editor #(
	parameter int unsigned LINE_LIMIT = 255
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	sc2a_scan_if.sink         scan_in,
	sc2a_event_if.source      event_out
);

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned PTR_W  = $clog2(QDEPTH);
	localparam int unsigned CNT_W  = PTR_W + 1;

	// Architectural state
	logic [3:0] mod_q;
	logic [7:0] len_q;

	// Output queue
	sc2a_pkg::event_item_t queue_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	logic       accept;
	logic       pop;
	logic [7:0] code;
	logic [6:0] key;
	logic       released;
	logic [6:0] ch;
	logic       have_flush;
	logic       have_main;
	logic [1:0] main_kind;
	logic [6:0] main_char;
	logic [3:0] mod_d;
	logic [7:0] len_d;
	logic [1:0] n_push;
	sc2a_pkg::event_item_t slot0;
	sc2a_pkg::event_item_t slot1;

	// Room for the worst case of two events
	assign scan_in.ready = (cnt_q <= CNT_W'(QDEPTH - 2));
	assign accept        = scan_in.valid && scan_in.ready;

	assign event_out.valid   = (cnt_q != '0);
	assign event_out.payload = queue_q[rd_ptr_q];
	assign pop               = event_out.valid && event_out.ready;

	assign code     = scan_in.payload.scan_code;
	assign key      = code[6:0];
	assign released = code[7];
	assign ch       = sc2a_pkg::key_char(key);

	// Decode one scancode against the current state
	always_comb begin
		have_flush = 1'b0;
		have_main  = 1'b0;
		main_kind  = sc2a_pkg::EV_ECHO;
		main_char  = '0;
		mod_d      = mod_q;
		len_d      = len_q;

		if (code == sc2a_pkg::CODE_BACKSPACE) begin
			if (len_q != '0) begin
				len_d     = len_q - 8'd1;
				have_main = 1'b1;
				main_kind = sc2a_pkg::EV_ERASE;
			end
		end else if (code == sc2a_pkg::CODE_ENTER) begin
			len_d     = '0;
			have_main = 1'b1;
			main_kind = sc2a_pkg::EV_NEWLINE;
		end else begin
			// Full line is flushed before anything else
			if (len_q == 8'(LINE_LIMIT)) begin
				have_flush = 1'b1;
				len_d      = '0;
			end
			if (ch == '0) begin
				case (key)
					sc2a_pkg::KEY_LCTRL:  mod_d[sc2a_pkg::MOD_CTRL]  = !released;
					sc2a_pkg::KEY_LSHIFT,
					sc2a_pkg::KEY_RSHIFT: mod_d[sc2a_pkg::MOD_SHIFT] = !released;
					sc2a_pkg::KEY_LALT:   mod_d[sc2a_pkg::MOD_ALT]   = !released;
					default: ;
				endcase
			end else if (!released) begin
				have_main = 1'b1;
				main_kind = sc2a_pkg::EV_ECHO;
				main_char = ch;
				// Letters lowercase unless shift is held
				if (!mod_q[sc2a_pkg::MOD_SHIFT] && ch >= sc2a_pkg::ASCII_UPPER_A &&
				    ch <= sc2a_pkg::ASCII_UPPER_Z) begin
					main_char = ch + sc2a_pkg::ASCII_CASE_OFS;
				end
				len_d = len_d + 8'd1;
			end
		end
	end

	// Pack events into queue order: flush newline first, then the main event
	always_comb begin
		n_push = {1'b0, have_flush} + {1'b0, have_main};

		slot0.event_kind    = have_flush ? sc2a_pkg::EV_NEWLINE : main_kind;
		slot0.char_code     = have_flush ? 7'd0 : main_char;
		slot0.modifier_bits = mod_d;
		slot0.last_of_run   = (n_push == 2'd1);

		slot1.event_kind    = main_kind;
		slot1.char_code     = main_char;
		slot1.modifier_bits = mod_d;
		slot1.last_of_run   = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= '0;
			len_q <= '0;
		end else if (accept) begin
			mod_q <= mod_d;
			len_q <= len_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && n_push != 2'd0) begin
			queue_q[wr_ptr_q] <= slot0;
		end
		if (accept && n_push == 2'd2) begin
			queue_q[wr_ptr_q + PTR_W'(1)] <= slot1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + (accept ? CNT_W'(n_push) : CNT_W'(0)) - CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`default_nettype none

// Bench for the set-1 scancode line editor. It sends scancodes on scan_in and
// checks every event that comes out of event_out against the directed table or a
// predictor that keeps its own modifier bits and line length.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          LINE_LIMIT  = 255;
	localparam int          RAND_ITEMS  = 1250;
	localparam int          CYCLE_LIMIT = 400000;
	localparam int          DRAIN_LIMIT = 2000;
	localparam int          HOLD_CYCLES = 200;
	localparam logic [7:0]  RELEASE_BIT = 8'h80;

	// Characters of the US layout by make code; zero means no character.
	localparam logic [6:0] US_KEYS [0:57] = '{
		7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h00, 7'h00,
		7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4F, 7'h50, 7'h5B, 7'h5D, 7'h00, 7'h00, 7'h41, 7'h53,
		7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h5A, 7'h58, 7'h43, 7'h56,
		7'h42, 7'h4E, 7'h4D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00,
		7'h00, 7'h20
	};

	// One row of the directed part. Rows with typed set carry the one event
	// they must cause (or none); the rest go through the predictor.
	typedef struct packed {
		logic [7:0]            code;
		logic                  typed;
		logic                  has_event;
		sc2a_pkg::event_item_t want;
	} dir_row_t;

	localparam dir_row_t DIR_TAB [0:24] = '{
		// backspace on an empty line: nothing
		'{sc2a_pkg::CODE_BACKSPACE, 1'b1, 1'b0, '{sc2a_pkg::EV_ECHO, 7'h00, 4'h0, 1'b0}},
		'{sc2a_pkg::CODE_ENTER, 1'b1, 1'b1, '{sc2a_pkg::EV_NEWLINE, 7'h00, 4'h0, 1'b1}},
		// 'a' lowercased, its release is silent
		'{8'h1E, 1'b1, 1'b1, '{sc2a_pkg::EV_ECHO,    7'h61, 4'h0, 1'b1}},
		'{8'h9E, 1'b1, 1'b0, '{sc2a_pkg::EV_ECHO,    7'h00, 4'h0, 1'b0}},
		// left shift: capital letter, digits unchanged
		'{8'h2A, 1'b1, 1'b0, '{sc2a_pkg::EV_ECHO,    7'h00, 4'h0, 1'b0}},
		'{8'h1E, 1'b1, 1'b1, '{sc2a_pkg::EV_ECHO,    7'h41, 4'h1, 1'b1}},
		'{8'h02, 1'b1, 1'b1, '{sc2a_pkg::EV_ECHO,    7'h31, 4'h1, 1'b1}},
		'{8'hAA, 1'b1, 1'b0, '{sc2a_pkg::EV_ECHO,    7'h00, 4'h0, 1'b0}},
		// right shift
		'{8'h36, 1'b1, 1'b0, '{sc2a_pkg::EV_ECHO,    7'h00, 4'h0, 1'b0}},
		'{8'h10, 1'b1, 1'b1, '{sc2a_pkg::EV_ECHO,    7'h51, 4'h1, 1'b1}},
		'{8'hB6, 1'b1, 1'b0, '{sc2a_pkg::EV_ECHO,    7'h00, 4'h0, 1'b0}},
		// ctrl and alt held: bits show up, case stays lower
		'{8'h1D, 1'b1, 1'b0, '{sc2a_pkg::EV_ECHO,    7'h00, 4'h0, 1'b0}},
		'{8'h38, 1'b1, 1'b0, '{sc2a_pkg::EV_ECHO,    7'h00, 4'h0, 1'b0}},
		'{8'h39, 1'b1, 1'b1, '{sc2a_pkg::EV_ECHO,    7'h20, 4'hA, 1'b1}},
		'{8'h2C, 1'b0, 1'b0, '0},
		'{8'h9D, 1'b1, 1'b0, '{sc2a_pkg::EV_ECHO,    7'h00, 4'h0, 1'b0}},
		'{8'hB8, 1'b1, 1'b0, '{sc2a_pkg::EV_ECHO,    7'h00, 4'h0, 1'b0}},
		'{sc2a_pkg::CODE_BACKSPACE, 1'b1, 1'b1, '{sc2a_pkg::EV_ERASE, 7'h00, 4'h0, 1'b1}},
		// backspace and enter releases, extremes, keys past the table
		'{8'h8E, 1'b1, 1'b0, '{sc2a_pkg::EV_ECHO,    7'h00, 4'h0, 1'b0}},
		'{8'h9C, 1'b1, 1'b0, '{sc2a_pkg::EV_ECHO,    7'h00, 4'h0, 1'b0}},
		'{8'h00, 1'b1, 1'b0, '{sc2a_pkg::EV_ECHO,    7'h00, 4'h0, 1'b0}},
		'{8'hFF, 1'b1, 1'b0, '{sc2a_pkg::EV_ECHO,    7'h00, 4'h0, 1'b0}},
		'{8'h3A, 1'b1, 1'b0, '{sc2a_pkg::EV_ECHO,    7'h00, 4'h0, 1'b0}},
		'{8'h2B, 1'b0, 1'b0, '0},
		'{sc2a_pkg::CODE_ENTER, 1'b1, 1'b1, '{sc2a_pkg::EV_NEWLINE, 7'h00, 4'h0, 1'b1}}
	};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	sc2a_scan_if  scan_in ();
	sc2a_event_if event_out ();

	scancode_to_ascii_line_editor #(
		.LINE_LIMIT(LINE_LIMIT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.scan_in  (scan_in),
		.event_out(event_out)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Predictor state
	logic [3:0]            held_mods = '0;
	logic [7:0]            line_len  = '0;
	sc2a_pkg::event_item_t pending_line_events [$];

	// Idle shaping, set per burst by the stimulus process
	int send_gap_max = 0;
	int recv_gap_max = 0;
	int hold_req     = 0;

	// Run statistics
	int failures       = 0;
	int events_checked = 0;
	int scans_sent     = 0;
	int active_scans   = 0;
	int line_flushes   = 0;
	int cycle_count    = 0;

	task automatic log_failure(input string what, input sc2a_pkg::event_item_t want,
			input sc2a_pkg::event_item_t got);
		failures++;
		if (failures <= 10) begin
			$display("%0t %s: want kind=%0d char=%02h mods=%h last=%b",
				$realtime, what, want.event_kind, want.char_code, want.modifier_bits,
				want.last_of_run);
			$display("    got kind=%0d char=%02h mods=%h last=%b",
				got.event_kind, got.char_code, got.modifier_bits, got.last_of_run);
		end
	endtask

	// Works out the events of one scancode and updates line length and
	// modifiers. active tells whether the scancode did anything at all.
	task automatic predict_line_events(input logic [7:0] code, input bit keep,
			output bit active);
		logic [6:0]            key;
		logic [6:0]            ch;
		logic                  up;
		logic [3:0]            mods_was;
		sc2a_pkg::event_item_t evs [$];
		key      = code[6:0];
		up       = code[7];
		mods_was = held_mods;
		if (code == sc2a_pkg::CODE_BACKSPACE) begin
			if (line_len != 0) begin
				line_len--;
				evs.push_back('{sc2a_pkg::EV_ERASE, 7'h00, 4'h0, 1'b0});
			end
		end else if (code == sc2a_pkg::CODE_ENTER) begin
			line_len = '0;
			evs.push_back('{sc2a_pkg::EV_NEWLINE, 7'h00, 4'h0, 1'b0});
		end else begin
			ch = 7'h00;
			if (key <= sc2a_pkg::KEY_LAST_PRINTABLE)
				ch = US_KEYS[key];
			// a full line is flushed before anything else happens
			if (line_len == LINE_LIMIT) begin
				line_len = '0;
				line_flushes++;
				evs.push_back('{sc2a_pkg::EV_NEWLINE, 7'h00, 4'h0, 1'b0});
			end
			if (ch == 7'h00) begin
				case (key)
					sc2a_pkg::KEY_LCTRL: held_mods[sc2a_pkg::MOD_CTRL] = !up;
					sc2a_pkg::KEY_LSHIFT,
					sc2a_pkg::KEY_RSHIFT: held_mods[sc2a_pkg::MOD_SHIFT] = !up;
					sc2a_pkg::KEY_LALT: held_mods[sc2a_pkg::MOD_ALT] = !up;
					default: ;
				endcase
			end else if (!up) begin
				if (!held_mods[sc2a_pkg::MOD_SHIFT] && ch >= sc2a_pkg::ASCII_UPPER_A
						&& ch <= sc2a_pkg::ASCII_UPPER_Z)
					ch = ch + sc2a_pkg::ASCII_CASE_OFS;
				line_len++;
				evs.push_back('{sc2a_pkg::EV_ECHO, ch, 4'h0, 1'b0});
			end
		end
		// modifiers are reported as they stand after the scancode
		foreach (evs[i]) begin
			evs[i].modifier_bits = held_mods;
			evs[i].last_of_run   = (i == evs.size() - 1);
			if (keep)
				pending_line_events.push_back(evs[i]);
		end
		active = (evs.size() != 0) || (held_mods != mods_was);
	endtask

	// Offers one scancode after a random gap and holds it until taken.
	task automatic send_scancode(input logic [7:0] code, input bit typed,
			input bit has_event, input sc2a_pkg::event_item_t want);
		int gap;
		bit active;
		gap = $urandom_range(0, send_gap_max);
		if (gap != 0) begin
			scan_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		scan_in.valid             <= 1'b1;
		scan_in.payload.scan_code <= code;
		do @(posedge clk); while (!scan_in.ready);
		predict_line_events(code, !typed, active);
		if (typed && has_event)
			pending_line_events.push_back(want);
		scans_sent++;
		if (active)
			active_scans++;
	endtask

	// Random scancode. Long-line mode keeps backspace and enter out so the
	// line fills up, and throws special keys at a full line.
	function automatic logic [7:0] pick_scancode(input bit long_line);
		int         r;
		logic [6:0] key;
		logic [7:0] c;
		do key = 7'($urandom_range(0, 57)); while (US_KEYS[key] == 7'h00);
		r = $urandom_range(0, 99);
		if (long_line && line_len == LINE_LIMIT)
			r = 100 + $urandom_range(0, 4);
		case ($urandom_range(0, 3))
			0: c = {1'b0, sc2a_pkg::KEY_LCTRL};
			1: c = {1'b0, sc2a_pkg::KEY_LSHIFT};
			2: c = {1'b0, sc2a_pkg::KEY_RSHIFT};
			default: c = {1'b0, sc2a_pkg::KEY_LALT};
		endcase
		if ($urandom_range(0, 1) != 0)
			c = c | RELEASE_BIT;
		if (r >= 100) begin
			// full line: flush paired with each kind of key
			case (r - 100)
				0: c = sc2a_pkg::CODE_BACKSPACE;
				1: c = sc2a_pkg::CODE_ENTER;
				2: c = sc2a_pkg::CODE_BACKSPACE | RELEASE_BIT;
				3: c = sc2a_pkg::CODE_ENTER | RELEASE_BIT;
				default: c = {1'b0, key};
			endcase
		end else if (long_line) begin
			if (r < 72)
				c = {1'b0, key};
			else if (r < 84)
				c = {1'b1, key};
			else if (r >= 92) begin
				do c = 8'($urandom_range(0, 255));
				while (c == sc2a_pkg::CODE_BACKSPACE || c == sc2a_pkg::CODE_ENTER);
			end
		end else begin
			if (r < 45)
				c = {1'b0, key};
			else if (r < 58)
				c = {1'b1, key};
			else if (r < 70)
				;
			else if (r < 80)
				c = sc2a_pkg::CODE_BACKSPACE;
			else if (r < 85)
				c = sc2a_pkg::CODE_ENTER;
			else if (r < 88)
				c = ($urandom_range(0, 1) != 0) ? (sc2a_pkg::CODE_BACKSPACE | RELEASE_BIT)
					: (sc2a_pkg::CODE_ENTER | RELEASE_BIT);
			else
				c = 8'($urandom_range(0, 255));
		end
		return c;
	endfunction

	// Event sink: random stall before each item, or one long hold when asked
	// so the four-entry queue fills and scan_in backs up.
	initial begin : event_sink
		int stall;
		event_out.ready = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req != 0) begin
				stall    = hold_req;
				hold_req = 0;
			end else begin
				stall = $urandom_range(0, recv_gap_max);
			end
			if (stall != 0) begin
				event_out.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			event_out.ready <= 1'b1;
			do @(posedge clk); while (!event_out.valid);
		end
	end

	// Checker: every accepted event against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && event_out.valid && event_out.ready) begin
			events_checked++;
			if (pending_line_events.size() == 0) begin
				log_failure("event with nothing expected", '0, event_out.payload);
			end else begin
				sc2a_pkg::event_item_t want;
				want = pending_line_events.pop_front();
				if (event_out.payload.event_kind !== want.event_kind
						|| event_out.payload.char_code !== want.char_code
						|| event_out.payload.modifier_bits !== want.modifier_bits
						|| event_out.payload.last_of_run !== want.last_of_run)
					log_failure("event mismatch", want, event_out.payload);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d events outstanding", cycle_count,
				pending_line_events.size());
			$display("** scancode_to_ascii_line_editor: FAILED **");
			$finish;
		end
	end

	initial begin : stimulus
		int  burst;
		int  burst_len;
		int  rand_start;
		int  waited;
		bit  long_line;
		scan_in.valid   = 1'b0;
		scan_in.payload = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, no idling so the table runs back to back first
		foreach (DIR_TAB[i])
			send_scancode(DIR_TAB[i].code, DIR_TAB[i].typed, DIR_TAB[i].has_event,
				DIR_TAB[i].want);

		// Random part in bursts. The first burst, and now and then a later
		// one, types long lines to hit the full-line flush.
		rand_start = scans_sent;
		burst      = 0;
		while (scans_sent - rand_start < RAND_ITEMS) begin
			long_line = (burst == 0) || ($urandom_range(0, 7) == 0);
			burst_len = long_line ? $urandom_range(380, 440) : $urandom_range(8, 60);
			case ($urandom_range(0, 2))
				0: send_gap_max = 0;
				1: send_gap_max = 3;
				default: send_gap_max = 12;
			endcase
			case ($urandom_range(0, 2))
				0: recv_gap_max = 0;
				1: recv_gap_max = 3;
				default: recv_gap_max = 12;
			endcase
			if (burst == 2) begin
				// back-pressure burst: sink holds off, source sends flat out
				hold_req     = HOLD_CYCLES;
				send_gap_max = 0;
			end
			for (int n = 0; n < burst_len && scans_sent - rand_start < RAND_ITEMS;
					n++)
				send_scancode(pick_scancode(long_line), 1'b0, 1'b0, '0);
			burst++;
		end
		scan_in.valid <= 1'b0;

		// Drain, then keep watching to catch stray events
		waited = 0;
		while (pending_line_events.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (pending_line_events.size() != 0) begin
			$display("%0d expected events never arrived", pending_line_events.size());
			failures += pending_line_events.size();
		end

		$display("Sent %0d scancodes (%0d changed state) in %0d bursts; %0d events checked.",
			scans_sent, active_scans, burst, events_checked);
		$display("Full-line flushes: %0d; failures: %0d.", line_flushes, failures);
		if (failures == 0)
			$display("** scancode_to_ascii_line_editor: PASSED **");
		else
			$display("** scancode_to_ascii_line_editor: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire

>>> scancode_to_ascii_line_editor.f
rtl/sc2a_pkg.sv
rtl/sc2a_scan_if.sv
rtl/sc2a_event_if.sv
rtl/scancode_to_ascii_line_editor.sv
bench/tb_top.sv
